>>> rtl/periodic_request_scheduler_defines.svh
// Assertion macros for the periodic request scheduler.
// Included by periodic_request_scheduler, the RTL file that carries concurrent assertions; no dependencies.
`ifndef PERIODIC_REQUEST_SCHEDULER_DEFINES_SVH
`define PERIODIC_REQUEST_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("periodic_request_scheduler: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("periodic_request_scheduler: next-cycle check failed");

`endif

>>> rtl/prs_pkg.sv
// Shared types and constants for the periodic request scheduler.
// Used by prs_catchup and periodic_request_scheduler; no dependencies.
`default_nettype none

package prs_pkg;

   localparam int unsigned TIME_W    = 32;
   localparam int unsigned RETRY_W   = 8;
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned DIV_STEPS = TIME_W;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   localparam logic [TIME_W-1:0] DAY_SECONDS = TIME_W'(24 * 60 * 60);

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ARM        = 2'd0,
      CMD_RESCHEDULE = 2'd1,
      CMD_CHECK      = 2'd2,
      CMD_RETRY      = 2'd3
   } prs_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_RESP
   } prs_state_type;

   typedef enum logic [1:0] {
      UN_IDLE,
      UN_DIV,
      UN_BIAS,
      UN_MUL
   } prs_unit_state_type;

endpackage

`default_nettype wire

>>> rtl/prs_catchup.sv
// Catch-up unit: start + (q + 1) * period with q = (now - start) / period, or q = 0
// when now lies before start. One shared 34-bit adder: restoring divide, then shift-add.
`default_nettype none

module prs_catchup (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        calc_start,
   input  wire logic [prs_pkg::TIME_W-1:0]  now_time,
   input  wire logic [prs_pkg::TIME_W-1:0]  start_time,
   input  wire logic [prs_pkg::TIME_W-1:0]  period,
   output logic                             calc_done,
   output logic      [prs_pkg::TIME_W-1:0]  calc_result
);

   prs_pkg::prs_unit_state_type state_ff, state_in;
   logic [prs_pkg::TIME_W-1:0] dvd_ff, dvd_in;
   logic [prs_pkg::TIME_W-1:0] rem_ff, rem_in;
   logic [prs_pkg::TIME_W-1:0] acc_ff, acc_in;
   logic [prs_pkg::TIME_W-1:0] mcand_ff, mcand_in;
   logic [prs_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   logic [prs_pkg::TIME_W+1:0] add_a;
   logic [prs_pkg::TIME_W+1:0] add_b;
   logic                       add_sub;
   logic [prs_pkg::TIME_W+1:0] sum;
   logic                       borrow;

   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         prs_pkg::UN_IDLE: begin
            add_a   = {2'b00, now_time};
            add_b   = {2'b00, start_time};
            add_sub = 1'b1;
         end
         prs_pkg::UN_DIV: begin
            add_a   = {1'b0, rem_ff, dvd_ff[prs_pkg::TIME_W-1]};
            add_b   = {2'b00, period};
            add_sub = 1'b1;
         end
         prs_pkg::UN_BIAS: begin
            add_a = {2'b00, start_time};
            add_b = {2'b00, period};
         end
         prs_pkg::UN_MUL: begin
            add_a = {2'b00, acc_ff};
            add_b = dvd_ff[0] ? {2'b00, mcand_ff} : '0;
         end
      endcase
   end

   assign sum    = add_a + (add_sub ? ~add_b : add_b) + {{(prs_pkg::TIME_W+1){1'b0}}, add_sub};
   assign borrow = sum[prs_pkg::TIME_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prs_pkg::UN_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
   end

   always_comb begin
      state_in  = state_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      cnt_in    = cnt_ff;
      calc_done = 1'b0;
      unique case (state_ff)
         prs_pkg::UN_IDLE: begin
            if (calc_start) begin
               rem_in = '0;
               cnt_in = '0;
               if (borrow) begin
                  dvd_in   = '0;
                  state_in = prs_pkg::UN_BIAS;
               end else begin
                  dvd_in   = sum[prs_pkg::TIME_W-1:0];
                  state_in = prs_pkg::UN_DIV;
               end
            end
         end
         prs_pkg::UN_DIV: begin
            if (borrow) begin
               rem_in = {rem_ff[prs_pkg::TIME_W-2:0], dvd_ff[prs_pkg::TIME_W-1]};
            end else begin
               rem_in = sum[prs_pkg::TIME_W-1:0];
            end
            dvd_in = {dvd_ff[prs_pkg::TIME_W-2:0], ~borrow};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == prs_pkg::CNT_W'(prs_pkg::DIV_STEPS - 1)) begin
               state_in = prs_pkg::UN_BIAS;
            end
         end
         prs_pkg::UN_BIAS: begin
            acc_in   = sum[prs_pkg::TIME_W-1:0];
            mcand_in = period;
            state_in = prs_pkg::UN_MUL;
         end
         prs_pkg::UN_MUL: begin
            if (dvd_ff == '0) begin
               calc_done = 1'b1;
               state_in  = prs_pkg::UN_IDLE;
            end else begin
               acc_in   = sum[prs_pkg::TIME_W-1:0];
               mcand_in = {mcand_ff[prs_pkg::TIME_W-2:0], 1'b0};
               dvd_in   = {1'b0, dvd_ff[prs_pkg::TIME_W-1:1]};
            end
         end
      endcase
   end

   assign calc_result = acc_ff;

endmodule

`default_nettype wire

>>> rtl/periodic_request_scheduler.sv
// Periodic request scheduler: holds one fire time and a retry budget, and answers every
// command beat with one result beat. Arm, check and retry, and a reschedule that needs no
// catch-up, present their result beat in the cycle after the accept. A reschedule with a
// nonzero period whose advanced time still lies before now runs the catch-up unit: a
// 32-step restoring divide and a shift-add multiply that stops at the last set quotient
// bit, both on one shared adder; the divide is skipped when now lies before the start
// time. One command is in flight at a time; req_tready is low until its result beat is
// taken. Depends on prs_pkg, prs_catchup and periodic_request_scheduler_defines.svh.
`default_nettype none

`include "periodic_request_scheduler_defines.svh"

module periodic_request_scheduler (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [31:0]                    req_tdata,   // now_time[31:0]
   input  wire logic [1:0]                     req_tuser,   // cmd[1:0]
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [47:0]                    rsp_tdata,   // next_fire[31:0], due[32],
                                                            // tries_left[40:33], zero
   input  wire logic                           csr_we,
   input  wire logic [prs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [prs_pkg::TIME_W-1:0]     csr_wdata
);

   prs_pkg::prs_state_type state_ff, state_in;

   logic [prs_pkg::TIME_W-1:0]  period_ff;
   logic [prs_pkg::TIME_W-1:0]  start_ff;
   logic [prs_pkg::RETRY_W-1:0] limit_ff;
   logic [prs_pkg::TIME_W-1:0]  fire_ff, fire_in;
   logic [prs_pkg::RETRY_W-1:0] retries_ff, retries_in;
   logic [prs_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [prs_pkg::TIME_W-1:0]  rsp_fire_ff, rsp_fire_in;
   logic                        rsp_due_ff, rsp_due_in;
   logic [prs_pkg::RETRY_W-1:0] rsp_tries_ff, rsp_tries_in;

   prs_pkg::prs_cmd_type       cmd;
   logic [prs_pkg::TIME_W-1:0] req_now;
   logic [prs_pkg::TIME_W-1:0] cand;
   logic                       catch_up;
   logic                       req_beat;
   logic                       calc_start;
   logic                       calc_done;
   logic [prs_pkg::TIME_W-1:0] calc_result;

   assign cmd      = prs_pkg::prs_cmd_type'(req_tuser);
   assign req_now  = req_tdata;
   assign req_beat = req_tvalid && req_tready;
   assign cand     = fire_ff + ((period_ff == '0) ? prs_pkg::DAY_SECONDS : period_ff);
   assign catch_up = (period_ff != '0) && (cand < req_now);

   prs_catchup u_catchup (
      .clock       (clock),
      .reset       (reset),
      .calc_start  (calc_start),
      .now_time    (req_now),
      .start_time  (start_ff),
      .period      (period_ff),
      .calc_done   (calc_done),
      .calc_result (calc_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         start_ff  <= '0;
         limit_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            prs_pkg::CSR_PERIOD:      period_ff <= csr_wdata;
            prs_pkg::CSR_START_TIME:  start_ff  <= csr_wdata;
            prs_pkg::CSR_RETRY_LIMIT: limit_ff  <= csr_wdata[prs_pkg::RETRY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= prs_pkg::ST_IDLE;
         fire_ff    <= '0;
         retries_ff <= '0;
      end else begin
         state_ff   <= state_in;
         fire_ff    <= fire_in;
         retries_ff <= retries_in;
      end
      now_ff       <= now_in;
      rsp_fire_ff  <= rsp_fire_in;
      rsp_due_ff   <= rsp_due_in;
      rsp_tries_ff <= rsp_tries_in;
   end

   always_comb begin
      state_in     = state_ff;
      fire_in      = fire_ff;
      retries_in   = retries_ff;
      now_in       = now_ff;
      rsp_fire_in  = rsp_fire_ff;
      rsp_due_in   = rsp_due_ff;
      rsp_tries_in = rsp_tries_ff;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      calc_start   = 1'b0;
      unique case (state_ff)
         prs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_beat) begin
               now_in = req_now;
               unique case (cmd)
                  prs_pkg::CMD_ARM: begin
                     fire_in    = req_now;
                     retries_in = limit_ff;
                  end
                  prs_pkg::CMD_RESCHEDULE: begin
                     retries_in = limit_ff;
                     if (!catch_up) begin
                        fire_in = cand;
                     end
                  end
                  prs_pkg::CMD_CHECK: ;
                  prs_pkg::CMD_RETRY: begin
                     if (retries_ff != '0) begin
                        retries_in = retries_ff - 1'b1;
                     end
                  end
               endcase
               rsp_fire_in  = fire_in;
               rsp_due_in   = (req_now >= fire_in);
               rsp_tries_in = retries_in;
               if ((cmd == prs_pkg::CMD_RESCHEDULE) && catch_up) begin
                  calc_start = 1'b1;
                  state_in   = prs_pkg::ST_CALC;
               end else begin
                  state_in = prs_pkg::ST_RESP;
               end
            end
         end
         prs_pkg::ST_CALC: begin
            if (calc_done) begin
               fire_in      = calc_result;
               rsp_fire_in  = calc_result;
               rsp_due_in   = (now_ff >= calc_result);
               rsp_tries_in = retries_ff;
               state_in     = prs_pkg::ST_RESP;
            end
         end
         prs_pkg::ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = prs_pkg::ST_IDLE;
            end
         end
         default: state_in = prs_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tdata = {7'b0, rsp_tries_ff, rsp_due_ff, rsp_fire_ff};

   `PRS_ASSERT_SAME(a_one_in_flight, clock, reset, rsp_tvalid, !req_tready)
   `PRS_ASSERT_SAME(a_done_in_calc, clock, reset, calc_done, state_ff == prs_pkg::ST_CALC)
   `PRS_ASSERT_NEXT(a_done_to_rsp, clock, reset, calc_done, rsp_tvalid)
   `PRS_ASSERT_SAME(a_rsp_matches_state, clock, reset, rsp_tvalid,
                    (rsp_fire_ff == fire_ff) && (rsp_tries_ff == retries_ff))
   `PRS_ASSERT_NEXT(a_retry_spends, clock, reset,
                    req_beat && (cmd == prs_pkg::CMD_RETRY) && (retries_ff != '0),
                    retries_ff == prs_pkg::RETRY_W'($past(retries_ff) - 1'b1))

endmodule

`default_nettype wire

>>> bench/tb_periodic_request_scheduler.sv
// Self-checking bench for periodic_request_scheduler: a directed table, then random command
// phases under changing register settings, checked against an in-bench scheduler model or a
// row's own expected result. Depends on prs_pkg and the periodic_request_scheduler RTL.
`default_nettype none

module tb_periodic_request_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [prs_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1680;
   localparam int unsigned QUIET_LIMIT  = 4000;
   localparam int unsigned RSP_STALL    = 300;

   typedef struct packed {
      logic [prs_pkg::TIME_W-1:0]  fire;
      logic                        due;
      logic [prs_pkg::RETRY_W-1:0] tries;
   } fire_report_type;

   typedef struct {
      bit                            wr;
      logic [prs_pkg::CSR_IDX_W-1:0] idx;
      logic [prs_pkg::TIME_W-1:0]    val;
      prs_pkg::prs_cmd_type          cmd;
      logic [prs_pkg::TIME_W-1:0]    now;
      bit                            typed;
      fire_report_type               rep;
   } plan_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [31:0]                   req_tdata = '0;   // now_time[31:0]
   logic [1:0]                    req_tuser = '0;   // cmd[1:0]
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [47:0]                   rsp_tdata;  // next_fire[31:0], due[32], tries_left[40:33]
   logic                          csr_we = 1'b0;
   logic [prs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [prs_pkg::TIME_W-1:0]    csr_wdata = '0;

   logic [prs_pkg::TIME_W-1:0]  cfg_period = '0;
   logic [prs_pkg::TIME_W-1:0]  cfg_start = '0;
   logic [prs_pkg::RETRY_W-1:0] cfg_limit = '0;
   logic [prs_pkg::TIME_W-1:0]  sched_fire = '0;
   logic [prs_pkg::RETRY_W-1:0] sched_tries = '0;

   fire_report_type report_q[$];
   plan_row_type    plan[$];
   int unsigned     err_count = 0;
   int unsigned     quiet_cycles = 0;
   bit              send_gaps = 1'b1;
   bit              recv_gaps = 1'b1;
   bit              rsp_stall_req = 1'b0;

   periodic_request_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic fire_report_type apply_cmd(prs_pkg::prs_cmd_type c,
                                                 logic [prs_pkg::TIME_W-1:0] t);
      logic [prs_pkg::TIME_W-1:0] cand;
      logic [prs_pkg::TIME_W-1:0] q;
      logic [63:0]                boundary;
      fire_report_type            r;
      case (c)
         prs_pkg::CMD_ARM: begin
            sched_fire  = t;
            sched_tries = cfg_limit;
         end
         prs_pkg::CMD_RESCHEDULE: begin
            sched_tries = cfg_limit;
            if (cfg_period == '0) begin
               sched_fire = sched_fire + prs_pkg::DAY_SECONDS;
            end else begin
               cand = sched_fire + cfg_period;
               if (cand < t) begin
                  q = (t >= cfg_start) ? (t - cfg_start) / cfg_period : '0;
                  boundary = (64'(q) + 64'd1) * 64'(cfg_period);
                  cand = cfg_start + boundary[prs_pkg::TIME_W-1:0];
               end
               sched_fire = cand;
            end
         end
         prs_pkg::CMD_RETRY: begin
            if (sched_tries != '0) sched_tries = sched_tries - 1'b1;
         end
         prs_pkg::CMD_CHECK: ;
      endcase
      r.fire  = sched_fire;
      r.due   = (t >= sched_fire);
      r.tries = sched_tries;
      return r;
   endfunction

   function automatic plan_row_type blank_row();
      plan_row_type r;
      r.wr    = 1'b0;
      r.idx   = '0;
      r.val   = '0;
      r.cmd   = prs_pkg::CMD_CHECK;
      r.now   = '0;
      r.typed = 1'b0;
      r.rep   = '0;
      return r;
   endfunction

   function automatic plan_row_type csr_row(logic [prs_pkg::CSR_IDX_W-1:0] idx,
                                            logic [prs_pkg::TIME_W-1:0] val);
      plan_row_type r;
      r = blank_row();
      r.wr  = 1'b1;
      r.idx = idx;
      r.val = val;
      return r;
   endfunction

   function automatic plan_row_type cmd_row(prs_pkg::prs_cmd_type c,
                                            logic [prs_pkg::TIME_W-1:0] t);
      plan_row_type r;
      r = blank_row();
      r.cmd = c;
      r.now = t;
      return r;
   endfunction

   function automatic plan_row_type chk_row(prs_pkg::prs_cmd_type c,
                                            logic [prs_pkg::TIME_W-1:0] t,
                                            logic [prs_pkg::TIME_W-1:0] f, logic d,
                                            logic [prs_pkg::RETRY_W-1:0] n);
      plan_row_type r;
      r = cmd_row(c, t);
      r.typed     = 1'b1;
      r.rep.fire  = f;
      r.rep.due   = d;
      r.rep.tries = n;
      return r;
   endfunction

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [prs_pkg::TIME_W-1:0] pick_now();
      logic [prs_pkg::TIME_W-1:0] step;
      step = (cfg_period == '0) ? prs_pkg::DAY_SECONDS : cfg_period;
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom();
         3: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return cfg_start;
               default: return cfg_start - 1'b1;
            endcase
         end
         4, 5: return sched_fire + 32'($urandom_range(0, 10)) - 32'd5;
         6, 7: return sched_fire + step * 32'($urandom_range(1, 1000))
                      + 32'($urandom_range(0, 20));
         8: return cfg_start + 32'($urandom_range(0, 100)) - 32'd50;
         default: return sched_fire + step + 32'($urandom_range(0, 3)) - 32'd1;
      endcase
   endfunction

   task automatic send_cmd(prs_pkg::prs_cmd_type c, logic [prs_pkg::TIME_W-1:0] t,
                           bit typed, fire_report_type typed_rep);
      int unsigned     g;
      fire_report_type r;
      g = send_gaps ? gap_len() : 0;
      if (g != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      req_tuser  <= c;
      do @(posedge clock); while (!req_tready);
      r = apply_cmd(c, t);
      report_q.push_back(typed ? typed_rep : r);
   endtask

   // drop valid and drain every result before touching registers
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [prs_pkg::CSR_IDX_W-1:0] idx,
                            logic [prs_pkg::TIME_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         prs_pkg::CSR_PERIOD:      cfg_period = val;
         prs_pkg::CSR_START_TIME:  cfg_start  = val;
         prs_pkg::CSR_RETRY_LIMIT: cfg_limit  = val[prs_pkg::RETRY_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic new_phase();
      logic [prs_pkg::TIME_W-1:0] v;
      wait_idle();
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 6))
            0: v = '0;
            1: v = 32'd1;
            2: v = 32'($urandom_range(2, 1000));
            3: v = 32'($urandom_range(1000, 200000));
            4: v = $urandom();
            5: v = '1;
            default: v = 32'h8000_0000 | $urandom();
         endcase
         write_reg(prs_pkg::CSR_PERIOD, v);
      end
      if ($urandom_range(0, 9) < 6) begin
         case ($urandom_range(0, 4))
            0: v = '0;
            1: v = '1;
            2: v = 32'($urandom_range(0, 1000));
            3: v = sched_fire - 32'($urandom_range(0, 5000));
            default: v = $urandom();
         endcase
         write_reg(prs_pkg::CSR_START_TIME, v);
      end
      if ($urandom_range(0, 9) < 6) begin
         case ($urandom_range(0, 3))
            0: v = '0;
            1: v = 32'd255;
            2: v = 32'($urandom_range(1, 4));
            default: v = $urandom();
         endcase
         write_reg(prs_pkg::CSR_RETRY_LIMIT, v);
      end
      if ($urandom_range(0, 9) == 0) write_reg(CSR_UNUSED, $urandom());
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
   endtask

   initial begin
      int unsigned          n;
      int unsigned          done_rand;
      prs_pkg::prs_cmd_type c;
      int unsigned          r;

      // after reset every register and the state are zero
      plan.push_back(chk_row(prs_pkg::CMD_CHECK, 32'h0, 32'h0, 1'b1, 8'd0));
      plan.push_back(chk_row(prs_pkg::CMD_RETRY, 32'hFFFF_FFFF, 32'h0, 1'b1, 8'd0));
      plan.push_back(chk_row(prs_pkg::CMD_RESCHEDULE, 32'h0, 32'd86400, 1'b0, 8'd0));
      plan.push_back(csr_row(prs_pkg::CSR_RETRY_LIMIT, 32'd255));
      plan.push_back(csr_row(CSR_UNUSED, 32'hFFFF_FFFF));
      plan.push_back(chk_row(prs_pkg::CMD_ARM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd255));
      plan.push_back(chk_row(prs_pkg::CMD_RESCHEDULE, 32'h0, 32'd86399, 1'b0, 8'd255));
      plan.push_back(chk_row(prs_pkg::CMD_RETRY, 32'd86399, 32'd86399, 1'b1, 8'd254));
      plan.push_back(cmd_row(prs_pkg::CMD_CHECK, 32'd86398));
      plan.push_back(csr_row(prs_pkg::CSR_PERIOD, 32'hFFFF_FFFF));
      plan.push_back(csr_row(prs_pkg::CSR_START_TIME, 32'hFFFF_FFFF));
      plan.push_back(csr_row(prs_pkg::CSR_RETRY_LIMIT, 32'd1));
      plan.push_back(chk_row(prs_pkg::CMD_ARM, 32'h0, 32'h0, 1'b1, 8'd1));
      plan.push_back(chk_row(prs_pkg::CMD_RETRY, 32'h0, 32'h0, 1'b1, 8'd0));
      plan.push_back(chk_row(prs_pkg::CMD_RETRY, 32'h0, 32'h0, 1'b1, 8'd0));
      plan.push_back(cmd_row(prs_pkg::CMD_RESCHEDULE, 32'hFFFF_FFFF));
      plan.push_back(cmd_row(prs_pkg::CMD_RESCHEDULE, 32'd5));
      plan.push_back(csr_row(prs_pkg::CSR_PERIOD, 32'd10));
      plan.push_back(csr_row(prs_pkg::CSR_START_TIME, 32'd100));
      plan.push_back(csr_row(prs_pkg::CSR_RETRY_LIMIT, 32'd0));
      plan.push_back(chk_row(prs_pkg::CMD_ARM, 32'h0, 32'h0, 1'b1, 8'd0));
      plan.push_back(cmd_row(prs_pkg::CMD_RESCHEDULE, 32'd1000));
      plan.push_back(cmd_row(prs_pkg::CMD_ARM, 32'h0));
      plan.push_back(cmd_row(prs_pkg::CMD_RESCHEDULE, 32'd50));
      plan.push_back(cmd_row(prs_pkg::CMD_RESCHEDULE, 32'd110));
      plan.push_back(csr_row(prs_pkg::CSR_PERIOD, 32'd1));
      plan.push_back(csr_row(prs_pkg::CSR_START_TIME, 32'h0));
      plan.push_back(cmd_row(prs_pkg::CMD_ARM, 32'h0));
      plan.push_back(cmd_row(prs_pkg::CMD_RESCHEDULE, 32'hFFFF_FFFF));
      plan.push_back(csr_row(prs_pkg::CSR_PERIOD, 32'h8000_0000));
      plan.push_back(csr_row(prs_pkg::CSR_START_TIME, 32'h7FFF_FFFF));
      plan.push_back(cmd_row(prs_pkg::CMD_ARM, 32'h0));
      plan.push_back(cmd_row(prs_pkg::CMD_RESCHEDULE, 32'hFFFF_FFF0));
      plan.push_back(cmd_row(prs_pkg::CMD_CHECK, 32'hFFFF_FFFF));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].wr) begin
            wait_idle();
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            send_cmd(plan[i].cmd, plan[i].now, plan[i].typed, plan[i].rep);
         end
      end

      done_rand = 0;
      while (done_rand < RANDOM_ITEMS) begin
         new_phase();
         n = $urandom_range(30, 120);
         if (n > RANDOM_ITEMS - done_rand) n = RANDOM_ITEMS - done_rand;
         repeat (n) begin
            if (done_rand == 300 || done_rand == 1100) rsp_stall_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 15) c = prs_pkg::CMD_ARM;
            else if (r < 50) c = prs_pkg::CMD_RESCHEDULE;
            else if (r < 68) c = prs_pkg::CMD_CHECK;
            else c = prs_pkg::CMD_RETRY;
            send_cmd(c, pick_now(), 1'b0, '0);
            done_rand++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (report_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, report_q.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      int unsigned g;
      wait (reset == 1'b0);
      forever begin
         if (rsp_stall_req) begin
            // hold off long enough for the sender to back up
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (RSP_STALL) @(posedge clock);
            rsp_stall_req = 1'b0;
         end else begin
            g = recv_gaps ? gap_len() : 0;
            if (g != 0) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
               repeat (g - 1) @(negedge clock);
            end
            @(negedge clock);
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      fire_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (report_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_tdata);
            err_count++;
         end else begin
            want = report_q.pop_front();
            if (rsp_tdata[31:0] !== want.fire) begin
               $display("%0t: next_fire expected %h got %h", $time, want.fire, rsp_tdata[31:0]);
               err_count++;
            end
            if (rsp_tdata[32] !== want.due) begin
               $display("%0t: due expected %b got %b", $time, want.due, rsp_tdata[32]);
               err_count++;
            end
            if (rsp_tdata[40:33] !== want.tries) begin
               $display("%0t: tries_left expected %0d got %0d", $time, want.tries,
                        rsp_tdata[40:33]);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: watchdog, no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

`default_nettype wire
